### src/tac_pkg.sv
// Shared types, constants and command/status bundles of the tile average colour block.
package tac_pkg;

	// Fixed field widths
	localparam int PIX_W     = 8;
	localparam int DIM_W     = 13;
	localparam int POS_W     = 12;
	localparam int GRID_W    = 7;
	localparam int ROW_W     = 6;
	localparam int OUT_IDX_W = 6;
	localparam int ACC_W     = 32;
	localparam int DEN_W     = 25;
	localparam int AREA_W    = 25;
	localparam int DIV_LANES = 3;
	localparam int CFG_IDX_W = 2;

	// Limits on the clamped register values
	localparam int MAX_IMAGE_DIM  = 4096;
	localparam int GRID_ROW_LIMIT = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 2'd3;

	// Register reset values and the cell geometry that follows from them
	localparam int RST_W_I    = 640;
	localparam int RST_H_I    = 480;
	localparam int RST_ROWS_I = 8;
	localparam int RST_COLS_I = 8;
	localparam int RST_CW_I   = RST_W_I / RST_COLS_I;
	localparam int RST_CH_I   = RST_H_I / RST_ROWS_I;

	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(RST_W_I);
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(RST_H_I);
	localparam logic [GRID_W-1:0] RST_GRID_ROWS    = GRID_W'(RST_ROWS_I);
	localparam logic [GRID_W-1:0] RST_GRID_COLS    = GRID_W'(RST_COLS_I);
	localparam logic [DIM_W-1:0]  RST_CELL_W       = DIM_W'(RST_CW_I);
	localparam logic [DIM_W-1:0]  RST_CELL_H       = DIM_W'(RST_CH_I);
	localparam logic [DIM_W-1:0]  RST_GRID_W       = DIM_W'(RST_CW_I * RST_COLS_I);
	localparam logic [DIM_W-1:0]  RST_GRID_H       = DIM_W'(RST_CH_I * RST_ROWS_I);
	localparam logic [AREA_W-1:0] RST_AREA         = AREA_W'(RST_CW_I * RST_CH_I);

	// One column accumulator entry
	typedef struct packed {
		logic [ACC_W-1:0] r;
		logic [ACC_W-1:0] g;
		logic [ACC_W-1:0] b;
	} acc_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_AVG_DIV,
		S_LOAD,
		S_CFG_DIV,
		S_CFG_MUL,
		S_POS_DIV
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;     // take pixel, issue accumulator read, step position
		logic acc_write;  // update the column accumulator
		logic avg_start;  // start dividing the cell sums by the area
		logic cfg_start;  // start computing the cell size
		logic cw_load;    // take the cell size from the divider
		logic mul_load;   // register grid extent and cell area
		logic pos_start;  // start dividing the position by the cell size
		logic pos_load;   // take cell position from the divider
		logic out_load;   // load the result register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cell_end;   // pixel in flight closes a cell
		logic div_done;   // divider results are ready
	} status_t;

endpackage

### src/tile_average_color_top.sv
// Top level of the tile average colour block: controller plus datapath.
//
// Input channel: one RGB888 pixel per request on red/green/blue, raster order,
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: one request per finished cell (cell_row, cell_col, the three
// truncated channel means and frame_done), taken with out_valid high and
// out_stall low.
// Registers are written through cfg_we/cfg_index/cfg_data, one per cycle.
// Each pixel gets an accumulator read, then an add and write back on the
// single memory port, before the next pixel is taken. The last pixel of a cell
// adds a radix-2 division of the three column sums by the cell area, and its
// result is offered once the division is done and the output register can take it.
// Each register write is followed by a geometry update (two divisions and a
// multiply) during which in_stall stays high.
// Reset loads the default geometry of 640x480 in an 8x8 grid, ready at once;
// the accumulators are not cleared, every cell starts a fresh sum.
// A stalled result is held; the block takes further pixels meanwhile and only
// waits once the next cell result is ready.
module tile_average_color_top #(
	parameter int MAX_GRID_COLS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tac_pkg::PIX_W-1:0]     red,
	input  logic [tac_pkg::PIX_W-1:0]     green,
	input  logic [tac_pkg::PIX_W-1:0]     blue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tac_pkg::ROW_W-1:0]     cell_row,
	output logic [tac_pkg::OUT_IDX_W-1:0] cell_col,
	output logic [tac_pkg::PIX_W-1:0]     avg_red,
	output logic [tac_pkg::PIX_W-1:0]     avg_green,
	output logic [tac_pkg::PIX_W-1:0]     avg_blue,
	output logic                          frame_done,
	input  logic                          cfg_we,
	input  logic [tac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tac_pkg::DIM_W-1:0]     cfg_data
);
	import tac_pkg::*;

	cmd_t    cmd;
	status_t st;

	tac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.st        (st),
		.cmd       (cmd)
	);

	tac_datapath #(
		.MAX_GRID_COLS (MAX_GRID_COLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cmd        (cmd),
		.st         (st),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.avg_red    (avg_red),
		.avg_green  (avg_green),
		.avg_blue   (avg_blue),
		.frame_done (frame_done)
	);

endmodule

### src/tac_div.sv
// Restoring divider, one quotient bit per cycle, several lanes in lock step.
module tac_div (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [tac_pkg::DIV_LANES-1:0][tac_pkg::ACC_W-1:0] num,
	input  logic [tac_pkg::DIV_LANES-1:0][tac_pkg::DEN_W-1:0] den,
	output logic [tac_pkg::DIV_LANES-1:0][tac_pkg::ACC_W-1:0] quo,
	output logic [tac_pkg::DIV_LANES-1:0][tac_pkg::DEN_W-1:0] rem,
	output logic                                         done
);
	import tac_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [CNT_W-1:0]                     cnt_q;
	logic                                 done_q;
	logic [DIV_LANES-1:0][ACC_W-1:0]      quo_q;
	logic [DIV_LANES-1:0][DEN_W-1:0]      rem_q;
	logic [DIV_LANES-1:0][DEN_W-1:0]      den_q;
	logic [DIV_LANES-1:0][ACC_W-1:0]      quo_nxt;
	logic [DIV_LANES-1:0][DEN_W-1:0]      rem_nxt;

	// One trial subtraction per lane
	always_comb begin
		logic [DEN_W:0] sh;
		logic [DEN_W:0] diff;
		for (int i = 0; i < DIV_LANES; i++) begin
			sh   = {rem_q[i], quo_q[i][ACC_W-1]};
			diff = sh - {1'b0, den_q[i]};
			if (!diff[DEN_W]) begin
				rem_nxt[i] = diff[DEN_W-1:0];
				quo_nxt[i] = {quo_q[i][ACC_W-2:0], 1'b1};
			end else begin
				rem_nxt[i] = sh[DEN_W-1:0];
				quo_nxt[i] = {quo_q[i][ACC_W-2:0], 1'b0};
			end
		end
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(ACC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Lane registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

### src/tac_datapath.sv
// Datapath: registers, position counters, column accumulators, divider and result register.
module tac_datapath #(
	parameter int MAX_GRID_COLS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tac_pkg::DIM_W-1:0]        cfg_data,
	input  logic [tac_pkg::PIX_W-1:0]        red,
	input  logic [tac_pkg::PIX_W-1:0]        green,
	input  logic [tac_pkg::PIX_W-1:0]        blue,
	input  tac_pkg::cmd_t                    cmd,
	output tac_pkg::status_t                 st,
	output logic [tac_pkg::ROW_W-1:0]        cell_row,
	output logic [tac_pkg::OUT_IDX_W-1:0]    cell_col,
	output logic [tac_pkg::PIX_W-1:0]        avg_red,
	output logic [tac_pkg::PIX_W-1:0]        avg_green,
	output logic [tac_pkg::PIX_W-1:0]        avg_blue,
	output logic                             frame_done
);
	import tac_pkg::*;

	localparam int COL_W = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
	localparam int CMP_W = (COL_W > GRID_W) ? COL_W : GRID_W;

	// Configuration registers
	logic [DIM_W-1:0]  width_q, height_q;
	logic [GRID_W-1:0] rows_q, cols_q;

	// Derived geometry
	logic [DIM_W-1:0]  cw_q, ch_q, gx_q, gy_q;
	logic [AREA_W-1:0] area_q;
	logic              ok_q;

	// Position of the next pixel
	logic [POS_W-1:0]  px_q, py_q, xic_q, yic_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	// Pixel in flight
	logic [PIX_W-1:0]  red_s1, green_s1, blue_s1;
	logic              grid_s1, first_s1, last_s1, frame_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;

	// Accumulators
	acc_t              acc_mem [MAX_GRID_COLS];
	acc_t              rd_q;
	acc_t              sum_new;

	// Result register
	logic [ROW_W-1:0]     cell_row_q;
	logic [OUT_IDX_W-1:0] cell_col_q;
	logic [PIX_W-1:0]     avg_red_q, avg_green_q, avg_blue_q;
	logic                 frame_done_q;

	// Divider
	logic                              div_start, div_done;
	logic [DIV_LANES-1:0][ACC_W-1:0]   div_num, div_quo;
	logic [DIV_LANES-1:0][DEN_W-1:0]   div_den, div_rem;

	logic [DIM_W-1:0]  w_cl, h_cl;
	logic [GRID_W-1:0] cols_cl, rows_cl;
	logic              in_grid, first_px, last_px, frame_px;
	logic [DIM_W-1:0]  px1, py1;
	logic [DIM_W-1:0]  xic1, yic1;
	logic [2*DIM_W-1:0] prod_gx, prod_gy, prod_area;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			rows_q   <= RST_GRID_ROWS;
			cols_q   <= RST_GRID_COLS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_GRID_ROWS:    rows_q   <= cfg_data[GRID_W-1:0];
				CFG_GRID_COLS:    cols_q   <= cfg_data[GRID_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate registers to their legal ranges
	always_comb begin
		w_cl = (width_q == '0) ? DIM_W'(1) :
			(int'(width_q) > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : width_q;
		h_cl = (height_q == '0) ? DIM_W'(1) :
			(int'(height_q) > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : height_q;
		cols_cl = (cols_q == '0) ? GRID_W'(1) :
			(int'(cols_q) > MAX_GRID_COLS) ? GRID_W'(MAX_GRID_COLS) : cols_q;
		rows_cl = (rows_q == '0) ? GRID_W'(1) :
			(int'(rows_q) > GRID_ROW_LIMIT) ? GRID_W'(GRID_ROW_LIMIT) : rows_q;
	end

	// Grid extent and cell area
	assign prod_gx   = (2*DIM_W)'(cw_q) * (2*DIM_W)'(cols_cl);
	assign prod_gy   = (2*DIM_W)'(ch_q) * (2*DIM_W)'(rows_cl);
	assign prod_area = (2*DIM_W)'(cw_q) * (2*DIM_W)'(ch_q);

	// Cell geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q   <= RST_CELL_W;
			ch_q   <= RST_CELL_H;
			gx_q   <= RST_GRID_W;
			gy_q   <= RST_GRID_H;
			area_q <= RST_AREA;
			ok_q   <= 1'b1;
		end else begin
			if (cmd.cw_load) begin
				cw_q <= div_quo[0][DIM_W-1:0];
				ch_q <= div_quo[1][DIM_W-1:0];
			end
			if (cmd.mul_load) begin
				gx_q   <= prod_gx[DIM_W-1:0];
				gy_q   <= prod_gy[DIM_W-1:0];
				area_q <= prod_area[AREA_W-1:0];
				ok_q   <= (cw_q != '0) && (ch_q != '0);
			end
		end
	end

	// Classify the next pixel
	always_comb begin
		in_grid  = ok_q && (DIM_W'(px_q) < gx_q) && (DIM_W'(py_q) < gy_q);
		first_px = (xic_q == '0) && (yic_q == '0);
		last_px  = (DIM_W'(xic_q) == cw_q - DIM_W'(1)) &&
			(DIM_W'(yic_q) == ch_q - DIM_W'(1));
		frame_px = (CMP_W'(col_q) == CMP_W'(cols_cl - GRID_W'(1))) &&
			(row_q == ROW_W'(rows_cl - GRID_W'(1)));
		px1  = DIM_W'(px_q) + DIM_W'(1);
		py1  = DIM_W'(py_q) + DIM_W'(1);
		xic1 = DIM_W'(xic_q) + DIM_W'(1);
		yic1 = DIM_W'(yic_q) + DIM_W'(1);
	end

	// Position counters: step on each pixel, reload after a geometry change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= '0;
			py_q  <= '0;
			xic_q <= '0;
			yic_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.pos_load) begin
			col_q <= div_quo[0][COL_W-1:0];
			xic_q <= div_rem[0][POS_W-1:0];
			row_q <= div_quo[1][ROW_W-1:0];
			yic_q <= div_rem[1][POS_W-1:0];
		end else if (cmd.accept) begin
			if (px1 >= w_cl) begin
				px_q  <= '0;
				xic_q <= '0;
				col_q <= '0;
				if (py1 >= h_cl) begin
					py_q  <= '0;
					yic_q <= '0;
					row_q <= '0;
				end else begin
					py_q <= py1[POS_W-1:0];
					if (yic1 == ch_q) begin
						yic_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						yic_q <= yic1[POS_W-1:0];
					end
				end
			end else begin
				px_q <= px1[POS_W-1:0];
				if (xic1 == cw_q) begin
					xic_q <= '0;
					col_q <= col_q + COL_W'(1);
				end else begin
					xic_q <= xic1[POS_W-1:0];
				end
			end
		end
	end

	// Pixel stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_s1 <= 1'b0;
		end else if (cmd.accept) begin
			grid_s1 <= in_grid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			first_s1 <= first_px;
			last_s1  <= last_px;
			frame_s1 <= frame_px;
			col_s1   <= col_q;
			row_s1   <= row_q;
		end
	end

	// New column sums: restart on the first pixel of a cell
	always_comb begin
		sum_new.r = first_s1 ? ACC_W'(red_s1)   : rd_q.r + ACC_W'(red_s1);
		sum_new.g = first_s1 ? ACC_W'(green_s1) : rd_q.g + ACC_W'(green_s1);
		sum_new.b = first_s1 ? ACC_W'(blue_s1)  : rd_q.b + ACC_W'(blue_s1);
	end

	// Column accumulator memory
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= acc_mem[col_q];
		end
		if (cmd.acc_write && grid_s1) begin
			acc_mem[col_s1] <= sum_new;
		end
	end

	// Divider operand select
	always_comb begin
		div_num = '0;
		div_den = '0;
		if (cmd.avg_start) begin
			div_num[0] = sum_new.r;
			div_num[1] = sum_new.g;
			div_num[2] = sum_new.b;
			for (int i = 0; i < DIV_LANES; i++) begin
				div_den[i] = DEN_W'(area_q);
			end
		end else if (cmd.cfg_start) begin
			div_num[0] = ACC_W'(w_cl);
			div_den[0] = DEN_W'(cols_cl);
			div_num[1] = ACC_W'(h_cl);
			div_den[1] = DEN_W'(rows_cl);
			div_den[2] = DEN_W'(1);
		end else begin
			div_num[0] = ACC_W'(px_q);
			div_den[0] = DEN_W'(cw_q);
			div_num[1] = ACC_W'(py_q);
			div_den[1] = DEN_W'(ch_q);
			div_den[2] = DEN_W'(1);
		end
	end

	assign div_start = cmd.avg_start | cmd.cfg_start | cmd.pos_start;

	tac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_row_q   <= row_s1;
			cell_col_q   <= OUT_IDX_W'(col_s1);
			avg_red_q    <= div_quo[0][PIX_W-1:0];
			avg_green_q  <= div_quo[1][PIX_W-1:0];
			avg_blue_q   <= div_quo[2][PIX_W-1:0];
			frame_done_q <= frame_s1;
		end
	end

	assign st.cell_end = grid_s1 & last_s1;
	assign st.div_done = div_done;

	assign cell_row   = cell_row_q;
	assign cell_col   = cell_col_q;
	assign avg_red    = avg_red_q;
	assign avg_green  = avg_green_q;
	assign avg_blue   = avg_blue_q;
	assign frame_done = frame_done_q;

endmodule

### src/tac_ctrl.sv
// Controller state machine: handshakes, sequencing of accumulate, divide and geometry update.
module tac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  logic             cfg_we,
	input  tac_pkg::status_t st,
	output tac_pkg::cmd_t    cmd
);
	import tac_pkg::*;

	state_t state_q, state_nxt;
	logic   pend_q;
	logic   out_valid_q;

	// State register, pending geometry update, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			pend_q      <= cfg_we | (pend_q & ~cmd.cfg_start);
			out_valid_q <= cmd.out_load | (out_valid_q & out_stall);
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (pend_q) begin
					cmd.cfg_start = 1'b1;
					state_nxt     = S_CFG_DIV;
				end else if (!cfg_we) begin
					in_stall = 1'b0;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_nxt  = S_ACC;
					end
				end
			end
			S_ACC: begin
				cmd.acc_write = 1'b1;
				if (st.cell_end) begin
					cmd.avg_start = 1'b1;
					state_nxt     = S_AVG_DIV;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_AVG_DIV: begin
				if (st.div_done) begin
					state_nxt = S_LOAD;
				end
			end
			S_LOAD: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_CFG_DIV: begin
				if (st.div_done) begin
					cmd.cw_load = 1'b1;
					state_nxt   = S_CFG_MUL;
				end
			end
			S_CFG_MUL: begin
				cmd.mul_load  = 1'b1;
				cmd.pos_start = 1'b1;
				state_nxt     = S_POS_DIV;
			end
			S_POS_DIV: begin
				if (st.div_done) begin
					cmd.pos_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// An accepted pixel is accumulated in the following cycle
	a_accept_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_ACC))
		else $error("accepted pixel not followed by accumulate");

	// Divider results only show up while a division is awaited
	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == S_AVG_DIV || state_q == S_CFG_DIV ||
			state_q == S_POS_DIV))
		else $error("divider finished outside a wait state");

	// A register write holds off pixels until the geometry is recomputed
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("pixel accepted right after a register write");

	// A result is only loaded into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.out_load)
		else $error("pending result overwritten");

endmodule
